### hw/rtl/pper_pkg.sv
`default_nettype none

package pper_pkg;

    // data drive byte lanes carried on the input stream, ahead of the p and q parity lanes
    localparam int INPUT_DRIVES     = 6;
    localparam int DEF_DATA_DRIVES  = 6;

    localparam int BYTE_W           = 8;
    localparam int IDX_W            = 3;
    localparam int IN_TDATA_W       = (INPUT_DRIVES + 2) * BYTE_W;
    localparam int OUT_TDATA_W      = 24;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = INPUT_DRIVES;

    localparam logic [7:0] GF_LOW_POLY = 8'h1D;
    localparam logic [7:0] GF_TOP_BIT  = 8'h80;

    typedef enum logic [2:0] {
        ST_NONE    = 3'd0,
        ST_VIA_P   = 3'd1,
        ST_VIA_Q   = 3'd2,
        ST_TWO     = 3'd3,
        ST_UNRECOV = 3'd4
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOST_MASK = 2'd0,
        CFG_P_PRESENT = 2'd1,
        CFG_Q_PRESENT = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [INPUT_DRIVES-1:0] lost_mask;
        logic                    p_present;
        logic                    q_present;
    } t_cfg;

    // syndrome stage result, ready for the final multiply
    typedef struct packed {
        logic [IDX_W-1:0]  idx1;
        logic [IDX_W-1:0]  idx2;
        t_status           status;
        logic [BYTE_W-1:0] a;
        logic [BYTE_W-1:0] op;
        logic [BYTE_W-1:0] k;
        logic              last;
    } t_syn;

    typedef struct packed {
        logic [IDX_W-1:0]  idx1;
        logic [BYTE_W-1:0] byte1;
        logic [IDX_W-1:0]  idx2;
        logic [BYTE_W-1:0] byte2;
        t_status           status;
        logic              last;
    } t_res;

    typedef logic [7:0][BYTE_W-1:0] t_inv_tab;

    // gf(2^8) multiply, polynomial 0x11d
    function automatic logic [7:0] gf_mul(input logic [7:0] x, input logic [7:0] y);
        logic [7:0] acc;
        logic [7:0] xs;
        acc = '0;
        xs  = x;
        for (int k = 0; k < 8; k++) begin
            if (y[k]) begin
                acc = acc ^ xs;
            end
            if ((xs & GF_TOP_BIT) != 8'h00) begin
                xs = (xs << 1) ^ GF_LOW_POLY;
            end else begin
                xs = xs << 1;
            end
        end
        return acc;
    endfunction

    // inverses of the small coefficients 0..7, zero maps to zero
    function automatic t_inv_tab gf_inv_build();
        t_inv_tab tab;
        tab = '0;
        for (int c = 1; c < 8; c++) begin
            for (int i = 1; i < 256; i++) begin
                if (gf_mul(8'(c), 8'(i)) == 8'h01) begin
                    tab[c] = 8'(i);
                end
            end
        end
        return tab;
    endfunction

    localparam t_inv_tab GF_INV_TAB = gf_inv_build();

endpackage

`default_nettype wire

### hw/rtl/pper_syndrome.sv
`default_nettype none

module pper_syndrome import pper_pkg::*; #(
    parameter int DATA_DRIVES = DEF_DATA_DRIVES
) (
    input  wire logic [IN_TDATA_W-1:0] i_data,
    input  wire logic                  i_last,
    input  wire t_cfg                  i_cfg,
    output t_syn                       o_syn
);

    localparam int ACTIVE = (DATA_DRIVES < INPUT_DRIVES) ? DATA_DRIVES : INPUT_DRIVES;

    logic [BYTE_W-1:0] w_sum_p;
    logic [BYTE_W-1:0] w_sum_q;
    logic [BYTE_W-1:0] w_a;
    logic [BYTE_W-1:0] w_b;
    logic [1:0]        w_cnt;
    logic              w_have1;
    logic              w_have2;
    logic [IDX_W-1:0]  w_idx1;
    logic [IDX_W-1:0]  w_idx2;
    logic [IDX_W-1:0]  w_c1;
    logic [IDX_W-1:0]  w_c2;
    t_status           w_status;

    // fold present drives into p and q, find the two lowest lost drives
    always_comb begin
        w_sum_p = '0;
        w_sum_q = '0;
        w_cnt   = '0;
        w_have1 = 1'b0;
        w_have2 = 1'b0;
        w_idx1  = '0;
        w_idx2  = '0;
        for (int j = 0; j < ACTIVE; j++) begin
            if (i_cfg.lost_mask[j]) begin
                if (w_cnt != 2'd3) begin
                    w_cnt = w_cnt + 2'd1;
                end
                if (!w_have1) begin
                    w_idx1  = IDX_W'(j);
                    w_have1 = 1'b1;
                end else if (!w_have2) begin
                    w_idx2  = IDX_W'(j);
                    w_have2 = 1'b1;
                end
            end else begin
                w_sum_p = w_sum_p ^ i_data[j*BYTE_W +: BYTE_W];
                w_sum_q = w_sum_q ^ gf_mul(8'(j + 1), i_data[j*BYTE_W +: BYTE_W]);
            end
        end
    end

    assign w_a  = i_data[INPUT_DRIVES*BYTE_W +: BYTE_W] ^ w_sum_p;
    assign w_b  = i_data[(INPUT_DRIVES+1)*BYTE_W +: BYTE_W] ^ w_sum_q;
    assign w_c1 = w_idx1 + 3'd1;
    assign w_c2 = w_idx2 + 3'd1;

    always_comb begin
        if (w_cnt == 2'd0) begin
            w_status = ST_NONE;
        end else if (w_cnt == 2'd1 && i_cfg.p_present) begin
            w_status = ST_VIA_P;
        end else if (w_cnt == 2'd1 && i_cfg.q_present) begin
            w_status = ST_VIA_Q;
        end else if (w_cnt == 2'd2 && i_cfg.p_present && i_cfg.q_present) begin
            w_status = ST_TWO;
        end else begin
            w_status = ST_UNRECOV;
        end
    end

    // operands for the shared multiply in the solve stage
    always_comb begin
        o_syn.idx1   = w_idx1;
        o_syn.idx2   = w_idx2;
        o_syn.status = w_status;
        o_syn.a      = w_a;
        o_syn.last   = i_last;
        case (w_status)
            ST_VIA_Q: begin
                o_syn.k  = GF_INV_TAB[w_c1];
                o_syn.op = w_b;
            end
            ST_TWO: begin
                o_syn.k  = GF_INV_TAB[w_c1 ^ w_c2];
                o_syn.op = w_b ^ gf_mul({5'b0, w_c2}, w_a);
            end
            default: begin
                o_syn.k  = '0;
                o_syn.op = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

### hw/rtl/pper_solve.sv
`default_nettype none

module pper_solve import pper_pkg::*; (
    input  wire t_syn i_syn,
    output t_res      o_res
);

    logic [BYTE_W-1:0] w_prod;

    assign w_prod = gf_mul(i_syn.k, i_syn.op);

    always_comb begin
        o_res.idx1   = i_syn.idx1;
        o_res.idx2   = i_syn.idx2;
        o_res.status = i_syn.status;
        o_res.last   = i_syn.last;
        case (i_syn.status)
            ST_VIA_P: begin
                o_res.byte1 = i_syn.a;
                o_res.byte2 = '0;
            end
            ST_VIA_Q: begin
                o_res.byte1 = w_prod;
                o_res.byte2 = '0;
            end
            ST_TWO: begin
                // higher drive falls out of p once the lower one is known
                o_res.byte1 = w_prod;
                o_res.byte2 = i_syn.a ^ w_prod;
            end
            default: begin
                o_res.byte1 = '0;
                o_res.byte2 = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

### hw/rtl/pq_parity_erasure_rebuild.sv
// an accepted item enters the input register, then moves to the syndrome register
// and from there its result goes into the output register
// throughput: one item per cycle through input, syndrome and result registers while
// the output is free; a stalled output holds its item while the two earlier stages
// keep filling. reset (synchronous, active low) empties all stages, clears the lost
// mask and marks both parity drives present
`default_nettype none

module pq_parity_erasure_rebuild import pper_pkg::*; #(
    parameter int DATA_DRIVES = DEF_DATA_DRIVES
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // configuration writes
    input  wire logic                   i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    // input stream
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    // data_byte_0..data_byte_5, parity_p_byte, parity_q_byte
    input  wire logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  wire logic                   i_s_tlast,   // end_of_block
    // result stream
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    // first_lost_index, first_lost_byte, second_lost_index, second_lost_byte, zero pad
    output logic [OUT_TDATA_W-1:0]      o_m_tdata,
    output logic [2:0]                  o_m_tuser,   // rebuild_status
    output logic                        o_m_tlast    // end_of_block_out
);

    // configuration registers
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lost_mask <= '0;
            r_cfg.p_present <= 1'b1;
            r_cfg.q_present <= 1'b1;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_LOST_MASK: r_cfg.lost_mask <= i_cfg_wdata;
                CFG_P_PRESENT: r_cfg.p_present <= i_cfg_wdata[0];
                CFG_Q_PRESENT: r_cfg.q_present <= i_cfg_wdata[0];
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    // stage valids and ready chain, each stage moves when the next one frees up
    logic                  r_s1_v;
    logic                  r_s2_v;
    logic                  r_out_v;
    logic                  w_out_free;
    logic                  w_s2_free;
    logic                  w_s1_free;

    logic [IN_TDATA_W-1:0] r_s1_data;
    logic                  r_s1_last;
    t_syn                  w_syn;
    t_syn                  r_s2;
    t_res                  w_res;
    t_res                  r_out;

    assign w_out_free = !r_out_v || i_m_tready;
    assign w_s2_free  = !r_s2_v || w_out_free;
    assign w_s1_free  = !r_s1_v || w_s2_free;
    assign o_s_tready = w_s1_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (w_s1_free) begin
                r_s1_v <= i_s_tvalid;
            end
            if (w_s2_free) begin
                r_s2_v <= r_s1_v;
            end
            if (w_out_free) begin
                r_out_v <= r_s2_v;
            end
        end
    end

    // payload registers, loaded only when an item moves in
    always_ff @(posedge i_clk) begin
        if (w_s1_free && i_s_tvalid) begin
            r_s1_data <= i_s_tdata;
            r_s1_last <= i_s_tlast;
        end
        if (w_s2_free && r_s1_v) begin
            r_s2 <= w_syn;
        end
        if (w_out_free && r_s2_v) begin
            r_out <= w_res;
        end
    end

    // p/q syndromes, lost drive search and multiply operands
    pper_syndrome #(
        .DATA_DRIVES (DATA_DRIVES)
    ) u_syndrome (
        .i_data (r_s1_data),
        .i_last (r_s1_last),
        .i_cfg  (r_cfg),
        .o_syn  (w_syn)
    );

    // single gf multiply and byte selection
    pper_solve u_solve (
        .i_syn (r_s2),
        .o_res (w_res)
    );

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = {2'b00, r_out.byte2, r_out.idx2, r_out.byte1, r_out.idx1};
    assign o_m_tuser  = r_out.status;
    assign o_m_tlast  = r_out.last;

    // two rebuilt drives always come out in ascending order
    a_two_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out.status == ST_TWO) |-> (r_out.idx2 > r_out.idx1))
        else $error("two-drive result with indices out of order");

    // nothing lost means an all-zero result
    a_none_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out.status == ST_NONE) |->
        (r_out.idx1 == '0 && r_out.idx2 == '0 && r_out.byte1 == '0 && r_out.byte2 == '0))
        else $error("no-loss result carries nonzero fields");

    // single-drive rebuild leaves the second slot empty
    a_single_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && (r_out.status == ST_VIA_P || r_out.status == ST_VIA_Q)) |->
        (r_out.idx2 == '0 && r_out.byte2 == '0))
        else $error("single-drive result fills the second slot");

    // unrecoverable items carry no rebuilt bytes
    a_unrecov_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out.status == ST_UNRECOV) |->
        (r_out.byte1 == '0 && r_out.byte2 == '0))
        else $error("unrecoverable result carries rebuilt bytes");

    // input only stalls when every stage holds an item
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (r_s1_v && r_s2_v && r_out_v))
        else $error("input stalled with a free stage");

endmodule

`default_nettype wire

### tb/sv/pq_rebuild_checker.sv
`default_nettype none

module pq_rebuild_checker import pper_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    input  wire logic                   i_s_tvalid,
    input  wire logic                   i_s_tready,
    // data_byte_0..data_byte_5, parity_p_byte, parity_q_byte
    input  wire logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  wire logic                   i_s_tlast,   // end_of_block
    input  wire logic                   i_m_tvalid,
    input  wire logic                   i_m_tready,
    // first_lost_index, first_lost_byte, second_lost_index, second_lost_byte, zero pad
    input  wire logic [OUT_TDATA_W-1:0] i_m_tdata,
    input  wire logic [2:0]             i_m_tuser,   // rebuild_status
    input  wire logic                   i_m_tlast,   // end_of_block_out
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_checked
);

    // shadow of the register file, loaded at reset and by configuration writes
    logic [INPUT_DRIVES-1:0] lost_mask;
    logic                    p_here;
    logic                    q_here;

    t_res rebuild_due[$];
    t_res want;
    t_res seen;

    // shift-and-add from the top bit, reducing by x^8 + x^4 + x^3 + x^2 + 1
    function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] prod;
        prod = 8'h00;
        for (int k = 7; k >= 0; k--) begin
            prod = {prod[6:0], 1'b0} ^ (prod[7] ? GF_LOW_POLY : 8'h00);
            if (b[k]) begin
                prod = prod ^ a;
            end
        end
        return prod;
    endfunction

    function automatic logic [7:0] gf_recip(input logic [7:0] c);
        logic [7:0] found;
        found = 8'h00;
        for (int i = 1; i < 256; i++) begin
            if (gf_times(c, 8'(i)) == 8'h01) begin
                found = 8'(i);
            end
        end
        return found;
    endfunction

    function automatic t_res predict_rebuild(input logic [IN_TDATA_W-1:0] d, input logic l);
        t_res       r;
        logic [7:0] syn_p;
        logic [7:0] syn_q;
        logic [7:0] drv;
        logic [7:0] coef1;
        logic [7:0] coef2;
        int         n_lost;
        r      = '0;
        n_lost = 0;
        syn_p  = d[INPUT_DRIVES*BYTE_W +: BYTE_W];
        syn_q  = d[(INPUT_DRIVES+1)*BYTE_W +: BYTE_W];
        // fold the surviving drives into both syndromes
        for (int j = 0; j < INPUT_DRIVES; j++) begin
            drv = d[j*BYTE_W +: BYTE_W];
            if (lost_mask[j]) begin
                if (n_lost == 0) begin
                    r.idx1 = IDX_W'(j);
                end else if (n_lost == 1) begin
                    r.idx2 = IDX_W'(j);
                end
                n_lost++;
            end else begin
                syn_p = syn_p ^ drv;
                syn_q = syn_q ^ gf_times(8'(j + 1), drv);
            end
        end
        coef1    = {5'd0, r.idx1} + 8'd1;
        coef2    = {5'd0, r.idx2} + 8'd1;
        r.status = ST_UNRECOV;
        if (n_lost == 0) begin
            r.status = ST_NONE;
        end else if (n_lost == 1 && p_here) begin
            r.status = ST_VIA_P;
            r.byte1  = syn_p;
        end else if (n_lost == 1 && q_here) begin
            r.status = ST_VIA_Q;
            r.byte1  = gf_times(gf_recip(coef1), syn_q);
        end else if (n_lost == 2 && p_here && q_here) begin
            r.status = ST_TWO;
            r.byte1  = gf_times(gf_recip(coef1 ^ coef2), syn_q ^ gf_times(coef2, syn_p));
            r.byte2  = syn_p ^ r.byte1;
        end
        r.last = l;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            lost_mask = '0;
            p_here    = 1'b1;
            q_here    = 1'b1;
            rebuild_due.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_LOST_MASK: begin
                        lost_mask = i_cfg_wdata;
                    end
                    CFG_P_PRESENT: begin
                        p_here = i_cfg_wdata[0];
                    end
                    CFG_Q_PRESENT: begin
                        q_here = i_cfg_wdata[0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                rebuild_due.push_back(predict_rebuild(i_s_tdata, i_s_tlast));
            end
            if (i_m_tvalid && i_m_tready) begin
                seen.idx1   = i_m_tdata[2:0];
                seen.byte1  = i_m_tdata[10:3];
                seen.idx2   = i_m_tdata[13:11];
                seen.byte2  = i_m_tdata[21:14];
                seen.status = t_status'(i_m_tuser);
                seen.last   = i_m_tlast;
                if (rebuild_due.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10) begin
                        $display("unexpected result at %0t: tdata=%06h tuser=%0d",
                                 $realtime, i_m_tdata, i_m_tuser);
                    end
                end else begin
                    want = rebuild_due.pop_front();
                    o_checked++;
                    if (seen !== want || i_m_tdata[23:22] !== 2'b00) begin
                        o_fail_count++;
                        if (o_fail_count <= 10) begin
                            $display({"mismatch at %0t: expected idx1=%0d byte1=%02h ",
                                      "idx2=%0d byte2=%02h status=%0d last=%0b"},
                                     $realtime, want.idx1, want.byte1, want.idx2,
                                     want.byte2, want.status, want.last);
                            $display({"               got idx1=%0d byte1=%02h ",
                                      "idx2=%0d byte2=%02h status=%0d last=%0b pad=%0b"},
                                     seen.idx1, seen.byte1, seen.idx2, seen.byte2,
                                     i_m_tuser, seen.last, i_m_tdata[23:22]);
                        end
                    end
                end
            end
        end
        o_pending = rebuild_due.size();
    end

endmodule

`default_nettype wire

### tb/sv/pq_parity_erasure_rebuild_test.sv
`default_nettype none

module pq_parity_erasure_rebuild_test;
    import pper_pkg::*;

    // receiver hold-off long enough to fill every stage and block the input
    localparam int HOLD_CYCLES  = 60;
    localparam int ITEMS_PHASE  = 100;
    localparam int PHASES       = 15;
    localparam int LIMIT_CYCLES = 400000;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   s_tlast   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [2:0]             m_tuser;
    logic                   m_tlast;

    int fails;
    int pending;
    int checked;

    // idling odds in percent, changed per phase
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    // long receiver hold-off: requested here, counted down in the receiver process
    bit hold_req       = 1'b0;
    int hold_left      = 0;

    int n_sent         = 0;
    int n_settings     = 0;

    always #10 clk = ~clk;

    pq_parity_erasure_rebuild u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tlast   (s_tlast),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .o_m_tlast   (m_tlast)
    );

    pq_rebuild_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_index  (cfg_index),
        .i_cfg_wdata  (cfg_wdata),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fails),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // result side: random stalls, or a long hold-off when one is requested
    always @(posedge clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // one item per call, held until the block takes it
    task automatic push_item(input logic [IN_TDATA_W-1:0] d, input logic l);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tlast  <= l;
        @(posedge clk);
        while (!s_tready) begin
            @(posedge clk);
        end
        n_sent++;
    endtask

    // stop offering and let every outstanding result come out
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) begin
            @(posedge clk);
        end
        // three register stages behind the input
        repeat (4) @(posedge clk);
    endtask

    // all three registers, back to back, only while the pipe is empty
    task automatic apply_setting(input logic [5:0] mask, input logic p, input logic q);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_LOST_MASK;
        cfg_wdata <= mask;
        @(posedge clk);
        cfg_index <= CFG_P_PRESENT;
        cfg_wdata <= {5'd0, p};
        @(posedge clk);
        cfg_index <= CFG_Q_PRESENT;
        cfg_wdata <= {5'd0, q};
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        n_settings++;
    endtask

    // bytes lean toward the all-zero and all-one extremes
    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(9);
        if (r == 0) begin
            return 8'h00;
        end else if (r == 1) begin
            return 8'hFF;
        end
        return 8'($urandom);
    endfunction

    function automatic logic [IN_TDATA_W-1:0] pick_stripe();
        logic [IN_TDATA_W-1:0] d;
        for (int j = 0; j < INPUT_DRIVES + 2; j++) begin
            d[j*BYTE_W +: BYTE_W] = pick_byte();
        end
        return d;
    endfunction

    // mostly one or two lost drives, where the rebuild math lives
    function automatic logic [5:0] pick_lost_mask();
        logic [5:0] mask;
        int         r;
        int         n;
        mask = '0;
        r    = $urandom_range(99);
        if (r < 10) begin
            n = 0;
        end else if (r < 50) begin
            n = 1;
        end else if (r < 85) begin
            n = 2;
        end else begin
            n = $urandom_range(6, 3);
        end
        while ($countones(mask) < n) begin
            mask[$urandom_range(5)] = 1'b1;
        end
        return mask;
    endfunction

    initial begin
        logic [5:0] dir_mask [8];
        logic       dir_p    [8];
        logic       dir_q    [8];
        // nothing lost, single via p, single via q, two lost, two without q,
        // single with no parity, three lost, every drive lost
        dir_mask = '{6'b000000, 6'b000001, 6'b100000, 6'b100001,
                     6'b001100, 6'b010000, 6'b010101, 6'b111111};
        dir_p    = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
        dir_q    = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: every status, all-zero and all-one stripes, both tlast values
        for (int s = 0; s < 8; s++) begin
            apply_setting(dir_mask[s], dir_p[s], dir_q[s]);
            push_item('0, 1'b0);
            push_item('1, 1'b1);
            push_item(pick_stripe(), 1'b0);
            drain();
        end

        // random phases, each with its own setting and idling pattern
        for (int ph = 0; ph < PHASES; ph++) begin
            apply_setting(pick_lost_mask(), ($urandom_range(3) != 0), ($urandom_range(3) != 0));
            case (ph % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 54;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 54;
                end
                default: begin
                    send_idle_pct  = 34;
                    recv_stall_pct = 34;
                end
            endcase
            // sender keeps offering while the result side is held off
            if (ph == 2) begin
                hold_req = 1'b1;
            end
            for (int i = 0; i < ITEMS_PHASE; i++) begin
                // sender waits for the pipe to empty partway through
                if (ph == 5 && i == ITEMS_PHASE / 2) begin
                    drain();
                end
                push_item(pick_stripe(), ($urandom_range(7) == 0));
            end
            drain();
        end

        // final drain with a small tail for anything stray
        s_tvalid <= 1'b0;
        while (pending != 0) begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);

        $display("rebuild run: %0d stripe positions under %0d register settings",
                 n_sent, n_settings);
        $display("lost-drive counts 0..6 with parity on and off, %0d results compared",
                 checked);
        if (fails == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire

### pq_parity_erasure_rebuild.f
hw/rtl/pper_pkg.sv
hw/rtl/pper_syndrome.sv
hw/rtl/pper_solve.sv
hw/rtl/pq_parity_erasure_rebuild.sv
tb/sv/pq_rebuild_checker.sv
tb/sv/pq_parity_erasure_rebuild_test.sv
